// ----- sv/lzse_pkg.sv -----
// Package for the LZ sequence token encoder: payload types, queue entry and codes.
`default_nettype none
package lzse_pkg;

  // Longest literal run an item may carry.
  localparam logic [11:0] MaxRun = 12'd4095;

  typedef struct packed {
    logic [11:0] literal_run;
    logic [13:0] match_length;
    logic [21:0] distance;
    logic        end_of_stream;
  } lzse_in_t;

  typedef struct packed {
    logic [47:0] header;
    logic [2:0]  header_bytes;
    logic [12:0] literal_count;
    logic        last;
    logic        error;
  } lzse_out_t;

  // Match token form, picked by length and distance.
  typedef enum logic [1:0] {
    FORM_SHORT = 2'd0,
    FORM_MID   = 2'd1,
    FORM_WIDE  = 2'd2,
    FORM_EXT   = 2'd3
  } lzse_form_t;

  // Token the back end emits in a given cycle.
  typedef enum logic [2:0] {
    TOK_ERR   = 3'd0,
    TOK_LONG  = 3'd1,
    TOK_SHORT = 3'd2,
    TOK_MATCH = 3'd3,
    TOK_TAIL  = 3'd4,
    TOK_TERM  = 3'd5
  } lzse_tok_t;

  // Classified item as held in the queue; match header lacks the literal field.
  typedef struct packed {
    logic [11:0] run;
    logic        eos;
    logic        err;
    lzse_form_t  form;
    logic [47:0] mhdr;
    logic [2:0]  mbytes;
  } lzse_entry_t;

endpackage
`default_nettype wire

// ----- sv/lzse_front.sv -----
// Front end: checks an incoming sequence and builds its match token skeleton.
`default_nettype none
module lzse_front (
  input  wire lzse_pkg::lzse_in_t    item,
  output lzse_pkg::lzse_entry_t      entry
);

  logic [13:0] len;
  logic [21:0] mdist;
  logic [13:0] len3;
  logic [13:0] len4;
  logic [23:0] distf;
  logic [1:0]  dist_nb;
  logic        bad_match;

  assign len   = item.match_length;
  assign mdist = item.distance;
  assign len3  = len - 14'd3;
  assign len4  = len - 14'd4;

  // Flag matches no form can carry
  assign bad_match = (len < 14'd3) || ((len == 14'd3) && (mdist > 22'd511));

  // Distance field of the extended form
  always_comb begin
    if (mdist < 22'd32768) begin
      distf   = {8'd0, mdist[14:0], 1'b0};
      dist_nb = 2'd2;
    end else begin
      distf   = {mdist, 2'b01};
      dist_nb = 2'd3;
    end
  end

  // Pick the form and build its header with the literal field left clear
  always_comb begin
    entry.run  = item.literal_run;
    entry.eos  = item.end_of_stream;
    entry.err  = (item.literal_run > lzse_pkg::MaxRun) ||
                 (!item.end_of_stream && bad_match);
    if ((len <= 14'd10) && (mdist <= 22'd511)) begin
      entry.form   = lzse_pkg::FORM_SHORT;
      entry.mhdr   = 48'({mdist[8:0], len3[2:0], 4'b0000});
      entry.mbytes = 3'd2;
    end else if ((len <= 14'd67) && (mdist <= 22'd8191)) begin
      entry.form   = lzse_pkg::FORM_MID;
      entry.mhdr   = 48'({mdist[12:0], len4[5:0], 5'b00001});
      entry.mbytes = 3'd3;
    end else if ((len <= 14'd515) && (mdist <= 22'd131071)) begin
      entry.form   = lzse_pkg::FORM_WIDE;
      entry.mhdr   = 48'({mdist[16:0], len4[8:0], 6'b000011});
      entry.mbytes = 3'd4;
    end else if (len4 < 14'd128) begin
      entry.form   = lzse_pkg::FORM_EXT;
      entry.mhdr   = 48'({distf, len4[6:0], 1'b0, 8'h0F});
      entry.mbytes = 3'd2 + 3'(dist_nb);
    end else begin
      entry.form   = lzse_pkg::FORM_EXT;
      entry.mhdr   = {distf, len4, 2'b01, 8'h0F};
      entry.mbytes = 3'd3 + 3'(dist_nb);
    end
  end

endmodule
`default_nettype wire

// ----- sv/lzse_queue.sv -----
// Short queue of classified items between the front and back ends.
`default_nettype none
module lzse_queue #(
  parameter int DEPTH = 4
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         push,
  input  wire lzse_pkg::lzse_entry_t  wr_entry,
  output logic                        full,
  input  wire                         pop,
  output logic                        rd_valid,
  output lzse_pkg::lzse_entry_t       rd_entry
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  lzse_pkg::lzse_entry_t slots_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            do_push, do_pop;

  assign full     = (count_r == CntW'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_entry = slots_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && rd_valid;

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the entry on a push transfer
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= wr_entry;
    end
  end

endmodule
`default_nettype wire

// ----- sv/lzse_back.sv -----
// Back end: steps through one item's tokens, one per cycle while the output is not stalled, into the output register.
`default_nettype none
module lzse_back (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         q_valid,
  input  wire lzse_pkg::lzse_entry_t  q_entry,
  output logic                        q_pop,
  output logic                        out_valid,
  input  wire                         out_stall,
  output lzse_pkg::lzse_out_t         out_item
);

  lzse_pkg::lzse_entry_t cur_r;
  logic                  cur_valid_r, cur_valid_nxt;
  logic [11:0]           rl_r, rl_nxt;
  logic                  out_valid_r;
  lzse_pkg::lzse_out_t   out_r, tok_item;
  lzse_pkg::lzse_tok_t   tok;
  logic                  adv, emit, done, load;
  logic [8:0]            q8;
  logic [8:0]            lj;
  logic [3:0]            sj;
  logic [4:0]            sj1;
  logic [1:0]            tj;
  logic [12:0]           k;
  logic [47:0]           rfield;

  assign adv  = !out_valid_r || !out_stall;
  assign emit = cur_valid_r && adv;

  // Chunk sizes from the remaining run
  assign q8  = rl_r[11:3];
  assign lj  = q8 - 9'd1;
  assign sj  = (q8 > 9'd16) ? 4'd15 : 4'(q8 - 9'd1);
  assign sj1 = {1'b0, sj} + 5'd1;
  assign tj  = (rl_r > 12'd3) ? 2'd3 : rl_r[1:0];

  // Pick this cycle's token
  always_comb begin
    if (cur_r.err) begin
      tok = lzse_pkg::TOK_ERR;
    end else if (!cur_r.eos) begin
      if (rl_r > 12'd135) begin
        tok = lzse_pkg::TOK_LONG;
      end else if (rl_r >= 12'd8) begin
        tok = lzse_pkg::TOK_SHORT;
      end else begin
        tok = lzse_pkg::TOK_MATCH;
      end
    end else if (rl_r > 12'd8) begin
      tok = lzse_pkg::TOK_SHORT;
    end else if (rl_r != 12'd0) begin
      tok = lzse_pkg::TOK_TAIL;
    end else begin
      tok = lzse_pkg::TOK_TERM;
    end
  end

  // Place the trailing literal count into the match header
  always_comb begin
    unique case (cur_r.form)
      lzse_pkg::FORM_SHORT: rfield = 48'({rl_r[2:0], 1'b0});
      lzse_pkg::FORM_MID:   rfield = 48'({rl_r[2:0], 2'b00});
      lzse_pkg::FORM_WIDE:  rfield = 48'({rl_r[2:0], 3'b000});
      lzse_pkg::FORM_EXT:   rfield = 48'({rl_r[2:0], 5'b00000});
      default:              rfield = '0;
    endcase
  end

  // Build the result and the literals it consumes
  always_comb begin
    tok_item = '0;
    k        = '0;
    done     = 1'b0;
    unique case (tok)
      lzse_pkg::TOK_ERR: begin
        tok_item.error = 1'b1;
        done           = 1'b1;
      end
      lzse_pkg::TOK_LONG: begin
        k                     = {1'b0, q8, 3'b000};
        tok_item.header       = 48'({lj, 7'h3F});
        tok_item.header_bytes = 3'd2;
      end
      lzse_pkg::TOK_SHORT: begin
        k                     = 13'({sj1, 3'b000});
        tok_item.header       = 48'({sj, 4'h7});
        tok_item.header_bytes = 3'd1;
      end
      lzse_pkg::TOK_MATCH: begin
        k                     = 13'(rl_r);
        tok_item.header       = cur_r.mhdr | rfield;
        tok_item.header_bytes = cur_r.mbytes;
        done                  = 1'b1;
      end
      lzse_pkg::TOK_TAIL: begin
        k                     = 13'(tj);
        tok_item.header       = 48'({tj, 6'h1F});
        tok_item.header_bytes = 3'd1;
      end
      lzse_pkg::TOK_TERM: begin
        tok_item.header       = 48'h1F;
        tok_item.header_bytes = 3'd1;
        done                  = 1'b1;
      end
      default: begin
        done = 1'b1;
      end
    endcase
    tok_item.literal_count = k;
    tok_item.last          = done;
  end

  // Take the next item when idle or when the current one finishes
  assign load          = (!cur_valid_r || (emit && done)) && q_valid;
  assign q_pop         = load;
  assign cur_valid_nxt = (!cur_valid_r || (emit && done)) ? q_valid : cur_valid_r;
  assign rl_nxt        = load ? q_entry.run : (emit ? rl_r - k[11:0] : rl_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      if (adv) begin
        out_valid_r <= emit;
      end
    end
  end

  // Hold payload of the current item and the output register
  always_ff @(posedge clk) begin
    rl_r <= rl_nxt;
    if (load) begin
      cur_r <= q_entry;
    end
    if (emit) begin
      out_r <= tok_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_err_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.error |-> out_r.last && (out_r.header_bytes == 3'd0))
    else $error("error result without last or with header bytes");

  a_hdr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.error |-> (out_r.header_bytes != 3'd0))
    else $error("token result with no header bytes");

  a_run_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    emit && !done |=> (rl_r < $past(rl_r)))
    else $error("literal run did not shrink on a chunk token");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !cur_valid_r)
    else $error("output valid after reset");

endmodule
`default_nettype wire

// ----- sv/lz_sequence_token_encoder.sv -----
// Top level of the LZ sequence token encoder.
//
// Input channel in_*: one LZ sequence per transfer (literal run, match length,
// distance, end-of-stream). Output channel out_*: one token header per
// transfer, with the literal count the copier places after it; last marks
// the final token of a sequence and error a sequence that cannot be encoded.
// Both channels use valid/stall: a transfer happens when valid is high and
// stall is low.
// A sequence's first token passes through the queue, the back end's current
// item register and the output register. The back end sequencer emits one
// token per cycle while out_stall is low (typically one to three per sequence,
// up to 36 for a long end-of-stream tail). The front end classifies each sequence in
// the cycle it arrives and parks it in a QUEUE_DEPTH entry queue, so input
// transfers continue while the back end works or the receiver stalls.
// in_stall rises only when that queue is full; while out_stall is high the
// output register holds its token and the back end waits.
// Reset empties the queue and drops any token in flight.
`default_nettype none
module lz_sequence_token_encoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  output logic                      in_stall,
  input  wire lzse_pkg::lzse_in_t   in_item,
  output logic                      out_valid,
  input  wire                       out_stall,
  output lzse_pkg::lzse_out_t       out_item
);

  lzse_pkg::lzse_entry_t front_entry;
  lzse_pkg::lzse_entry_t head_entry;
  logic                  q_full, q_valid, q_pop;

  // Classify the incoming sequence
  lzse_front u_front (
    .item  (in_item),
    .entry (front_entry)
  );

  // Buffer classified sequences
  lzse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_valid),
    .wr_entry (front_entry),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_entry (head_entry)
  );

  // Emit tokens
  lzse_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_entry   (head_entry),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  assign in_stall = q_full;

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the LZ sequence token encoder.
`default_nettype none
module tb;

  // Hand-written tokens for the directed rows that carry one
  localparam lzse_pkg::lzse_out_t Reject     = '{48'd0, 3'd0, 13'd0, 1'b1, 1'b1};
  localparam lzse_pkg::lzse_out_t Terminator = '{48'h1F, 3'd1, 13'd0, 1'b1, 1'b0};
  localparam lzse_pkg::lzse_out_t NoToken    = '0;
  localparam int RandomSequences = 330;
  localparam int DrainLimit      = 20000;

  typedef struct {
    lzse_pkg::lzse_in_t  seq;
    bit                  typed;
    lzse_pkg::lzse_out_t want;
  } row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  lzse_pkg::lzse_in_t  in_item = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  lzse_pkg::lzse_out_t out_item;

  lzse_pkg::lzse_out_t tokens_due [$];
  lzse_pkg::lzse_out_t token_head;
  row_t      plan [0:24];
  bit        steady = 1'b0;
  int        n_fail = 0;
  int        n_sequences = 0;
  int        n_tokens = 0;
  int        n_rejects = 0;
  int        n_tails = 0;

  lz_sequence_token_encoder DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Queue one expected token
  function automatic void due_token(input logic [47:0] hdr, input int unsigned nbytes,
                                    input int unsigned lits, input bit fin);
    lzse_pkg::lzse_out_t tok;
    tok.header        = hdr;
    tok.header_bytes  = nbytes[2:0];
    tok.literal_count = lits[12:0];
    tok.last          = fin;
    tok.error         = 1'b0;
    tokens_due.push_back(tok);
  endfunction

  // Work out every token header one sequence produces
  function automatic void encode_sequence(input lzse_pkg::lzse_in_t s);
    int unsigned run, len, mdist, j, k, l1, pos;
    longint unsigned v;
    run   = s.literal_run;
    len   = s.match_length;
    mdist = s.distance;
    if (run > lzse_pkg::MaxRun ||
        (!s.end_of_stream && (len < 3 || (len == 3 && mdist > 511)))) begin
      tokens_due.push_back(Reject);
      n_rejects++;
      return;
    end
    if (!s.end_of_stream) begin
      // long chunks, then short chunks, leaving 0..7 for the match token
      while (run > 128 + 7) begin
        j = (run >> 3) - 1;
        if (j > 511) j = 511;
        k = (j + 1) * 8;
        due_token(48'h3F + (j << 7), 2, k, 1'b0);
        run -= k;
      end
      while (run >= 8) begin
        j = (run >> 3) - 1;
        if (j > 15) j = 15;
        k = (j + 1) * 8;
        due_token(48'h07 + (j << 4), 1, k, 1'b0);
        run -= k;
      end
      if (len <= 10 && mdist <= 511) begin
        v = (64'(mdist) << 7) | (64'(len - 3) << 4) | (64'(run) << 1);
        due_token(v[47:0], 2, run, 1'b1);
      end else if (len <= 67 && mdist <= 8191) begin
        v = (64'(mdist) << 11) | (64'(len - 4) << 5) | (64'(run) << 2) | 64'd1;
        due_token(v[47:0], 3, run, 1'b1);
      end else if (len <= 515 && mdist <= 131071) begin
        v = (64'(mdist) << 15) | (64'(len - 4) << 6) | (64'(run) << 3) | 64'd3;
        due_token(v[47:0], 4, run, 1'b1);
      end else begin
        // extended form: lead byte, then length and distance fields
        l1  = len - 4;
        v   = 64'h0F | (64'(run) << 5);
        if (l1 < 128) begin
          v |= (64'(l1 << 1) & 64'hFF) << 8;
          pos = 2;
        end else begin
          v |= (64'((l1 << 2) | 1) & 64'hFFFF) << 8;
          pos = 3;
        end
        if (mdist < 32768) begin
          v |= (64'(mdist << 1) & 64'hFFFF) << (8 * pos);
          pos += 2;
        end else begin
          v |= (64'((mdist << 2) | 1) & 64'hFF_FFFF) << (8 * pos);
          pos += 3;
        end
        due_token(v[47:0], pos, run, 1'b1);
      end
    end else begin
      // tail: short chunks while more than eight remain, then groups of up to three, then the terminator
      n_tails++;
      while (run > 8) begin
        j = (run >> 3) - 1;
        if (j > 15) j = 15;
        k = (j + 1) * 8;
        due_token(48'h07 + (j << 4), 1, k, 1'b0);
        run -= k;
      end
      while (run != 0) begin
        j = (run > 3) ? 3 : run;
        due_token(48'h1F + (j << 6), 1, j, 1'b0);
        run -= j;
      end
      due_token(48'h1F, 1, 0, 1'b1);
    end
  endfunction

  // Draw a sequence, mostly well formed, weighted toward short runs
  function automatic lzse_pkg::lzse_in_t random_sequence();
    lzse_pkg::lzse_in_t s;
    int unsigned r, m;
    s.end_of_stream = ($urandom_range(99) < 12);
    r = $urandom_range(99);
    if (r < 55)      s.literal_run = 12'($urandom_range(7));
    else if (r < 80) s.literal_run = 12'($urandom_range(135));
    else if (r < 95) s.literal_run = 12'($urandom_range(600));
    else             s.literal_run = 12'($urandom_range(4095));
    m = $urandom_range(99);
    if (m < 6) begin
      s.match_length = 14'($urandom_range(2));
      s.distance     = 22'($urandom_range(4194303));
    end else if (m < 10) begin
      s.match_length = 14'd3;
      s.distance     = 22'($urandom_range(4194303, 512));
    end else if (m < 35) begin
      s.match_length = 14'($urandom_range(10, 3));
      s.distance     = 22'($urandom_range(511));
    end else if (m < 55) begin
      s.match_length = 14'($urandom_range(67, 4));
      s.distance     = 22'($urandom_range(8191));
    end else if (m < 75) begin
      s.match_length = 14'($urandom_range(515, 4));
      s.distance     = 22'($urandom_range(131071));
    end else if (m < 92) begin
      s.match_length = 14'($urandom_range(16383, 4));
      s.distance     = 22'($urandom_range(4194303));
    end else begin
      s.match_length = 14'($urandom_range(16383));
      s.distance     = 22'($urandom_range(4194303));
    end
    return s;
  endfunction

  // Offer one sequence, idling at random, and hold it until the transfer
  task automatic send_sequence(input lzse_pkg::lzse_in_t s);
    while (!steady && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sequences++;
  endtask

  // Stall the result side at random, except in the steady stretch
  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 6);
  end

  // Check each result transfer against the oldest expected token
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      n_tokens++;
      if (tokens_due.size() == 0) begin
        $error("token with none expected: %h", out_item);
        n_fail++;
      end else begin
        token_head = tokens_due.pop_front();
        if (out_item.header !== token_head.header) begin
          $error("header: expected %h, got %h", token_head.header, out_item.header);
          n_fail++;
        end
        if (out_item.header_bytes !== token_head.header_bytes) begin
          $error("header_bytes: expected %0d, got %0d",
                 token_head.header_bytes, out_item.header_bytes);
          n_fail++;
        end
        if (out_item.literal_count !== token_head.literal_count) begin
          $error("literal_count: expected %0d, got %0d",
                 token_head.literal_count, out_item.literal_count);
          n_fail++;
        end
        if (out_item.last !== token_head.last) begin
          $error("last: expected %b, got %b", token_head.last, out_item.last);
          n_fail++;
        end
        if (out_item.error !== token_head.error) begin
          $error("error: expected %b, got %b", token_head.error, out_item.error);
          n_fail++;
        end
      end
    end
  end

  initial begin
    int guard;
    // run, match length, distance, end of stream
    plan = '{
      '{'{12'd0,    14'd0,     22'd0,       1'b1}, 1'b1, Terminator},
      '{'{12'd0,    14'd2,     22'd0,       1'b0}, 1'b1, Reject},
      '{'{12'd5,    14'd0,     22'd100,     1'b0}, 1'b1, Reject},
      '{'{12'd0,    14'd3,     22'd512,     1'b0}, 1'b1, Reject},
      '{'{12'd4095, 14'd1,     22'd4194303, 1'b0}, 1'b1, Reject},
      '{'{12'd0,    14'd3,     22'd511,     1'b0}, 1'b1,
        '{48'hFF80, 3'd2, 13'd0, 1'b1, 1'b0}},
      '{'{12'd7,    14'd3,     22'd0,       1'b0}, 1'b1,
        '{48'h0E, 3'd2, 13'd7, 1'b1, 1'b0}},
      '{'{12'd5,    14'd10,    22'd511,     1'b0}, 1'b0, NoToken},
      '{'{12'd3,    14'd11,    22'd8191,    1'b0}, 1'b0, NoToken},
      '{'{12'd7,    14'd67,    22'd0,       1'b0}, 1'b0, NoToken},
      '{'{12'd0,    14'd68,    22'd8191,    1'b0}, 1'b0, NoToken},
      '{'{12'd2,    14'd4,     22'd8192,    1'b0}, 1'b0, NoToken},
      '{'{12'd6,    14'd515,   22'd131071,  1'b0}, 1'b0, NoToken},
      '{'{12'd1,    14'd516,   22'd0,       1'b0}, 1'b0, NoToken},
      '{'{12'd7,    14'd131,   22'd131072,  1'b0}, 1'b0, NoToken},
      '{'{12'd0,    14'd4,     22'd4194303, 1'b0}, 1'b0, NoToken},
      '{'{12'd4095, 14'd16383, 22'd4194303, 1'b0}, 1'b0, NoToken},
      '{'{12'd135,  14'd4,     22'd0,       1'b0}, 1'b0, NoToken},
      '{'{12'd136,  14'd4,     22'd0,       1'b0}, 1'b0, NoToken},
      '{'{12'd8,    14'd3,     22'd0,       1'b0}, 1'b0, NoToken},
      '{'{12'd8,    14'd0,     22'd0,       1'b1}, 1'b0, NoToken},
      '{'{12'd9,    14'd0,     22'd0,       1'b1}, 1'b0, NoToken},
      '{'{12'd1,    14'd16383, 22'd4194303, 1'b1}, 1'b0, NoToken},
      '{'{12'd4095, 14'd16383, 22'd4194303, 1'b1}, 1'b0, NoToken},
      '{'{12'd3,    14'd2,     22'd0,       1'b1}, 1'b0, NoToken}
    };

    // hold reset, then release it once
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows: hand-typed token where given, predictor otherwise
    foreach (plan[i]) begin
      send_sequence(plan[i].seq);
      if (plan[i].typed) begin
        tokens_due.push_back(plan[i].want);
        if (plan[i].want.error) n_rejects++;
        if (plan[i].seq.end_of_stream) n_tails++;
      end else begin
        encode_sequence(plan[i].seq);
      end
    end

    // random sequences, with one stretch of back-to-back traffic
    for (int i = 0; i < RandomSequences; i++) begin
      lzse_pkg::lzse_in_t s;
      steady = (i >= 150 && i < 220);
      s = random_sequence();
      send_sequence(s);
      encode_sequence(s);
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    // drain the expected tokens, then watch for strays
    guard = 0;
    while (tokens_due.size() != 0 && guard < DrainLimit) begin
      @(posedge clk);
      guard++;
    end
    if (tokens_due.size() != 0) begin
      $error("%0d expected tokens never arrived", tokens_due.size());
      n_fail++;
    end
    repeat (8) @(posedge clk);

    $display("Covered %0d sequences (%0d end-of-stream, %0d rejected), %0d tokens checked.",
             n_sequences, n_tails, n_rejects, n_tokens);
    $display("All four match forms, chunk boundaries and tails up to the longest were hit.");
    if (n_fail == 0) begin
      $display("lz_sequence_token_encoder test passed");
    end else begin
      $display("lz_sequence_token_encoder test failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2000000;
    $display("lz_sequence_token_encoder test failed");
    $finish;
  end

endmodule
`default_nettype wire
